/* src/tty_line_discipline_assert.svh */
// assertion macros for the tty line discipline checker
// no dependencies; included by files that carry concurrent assertions
`ifndef TTY_LINE_DISCIPLINE_ASSERT_SVH
`define TTY_LINE_DISCIPLINE_ASSERT_SVH

// same-cycle implication under an active-low reset
`define TTYLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tty line discipline: check failed");

// next-cycle implication under an active-low reset
`define TTYLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tty line discipline: check failed");

`endif

/* src/ttyld_pkg.sv */
// shared types, codes and constants of the tty line discipline
// no dependencies; imported by every module of the block
`default_nettype none

package ttyld_pkg;

	localparam int unsigned LINE_DEPTH = 16;
	localparam int unsigned LEN_W      = $clog2(LINE_DEPTH + 1);
	localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int unsigned HEAD_MAX   = 4;
	localparam int unsigned HEAD_IDX_W = 2;
	localparam int unsigned HEAD_CNT_W = 3;
	localparam int unsigned CFG_IDX_W  = 3;

	// result destinations
	localparam logic [2:0] DEST_MASTER = 3'd0;
	localparam logic [2:0] DEST_SLAVE  = 3'd1;
	localparam logic [2:0] DEST_INTR   = 3'd2;
	localparam logic [2:0] DEST_SUSP   = 3'd3;
	localparam logic [2:0] DEST_EOF    = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_CR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LMODES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRLF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_KILL   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_EOF    = 3'd7;

	// local mode bits
	localparam int unsigned LM_ECHO  = 0;
	localparam int unsigned LM_ECHOE = 1;
	localparam int unsigned LM_CANON = 2;
	localparam int unsigned LM_SIG   = 3;

	// characters
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_UC_C  = 8'h43;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;

	// register defaults
	localparam logic [7:0] DEF_INTR  = 8'h03;
	localparam logic [7:0] DEF_SUSP  = 8'h1A;
	localparam logic [7:0] DEF_ERASE = 8'h7F;
	localparam logic [7:0] DEF_KILL  = 8'h15;
	localparam logic [7:0] DEF_EOF   = 8'h04;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       end_of_write;
	} in_word_t;

	typedef struct packed {
		logic [2:0] destination;
		logic [7:0] out_byte;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic       map_cr;
		logic [3:0] lmodes;
		logic       crlf;
		logic [7:0] intr;
		logic [7:0] susp;
		logic [7:0] erase;
		logic [7:0] kill;
		logic [7:0] eof;
	} cfg_t;

	// one result before the last flag is attached
	typedef struct packed {
		logic [2:0] dest;
		logic [7:0] val;
	} res_t;

	// what one input word turns into
	typedef struct packed {
		logic [HEAD_CNT_W-1:0]    head_cnt;
		res_t [HEAD_MAX-1:0]      head;
		logic [LEN_W-1:0]         rub_cnt;
		logic [LEN_W-1:0]         flush_cnt;
		logic                     tail;
		logic [LEN_W-1:0]         new_len;
	} plan_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

endpackage

`default_nettype wire

/* src/tty_line_discipline.sv */
// top level of the tty line discipline: config registers, decoder, line store, sequencer
// depends on ttyld_pkg, ttyld_cfg, ttyld_decode, ttyld_line_ram, ttyld_seq
//
//   channel | signals                          | payload
//   --------+----------------------------------+---------------------------------------
//   src     | src_valid, src_ready, src_word   | opcode, data_byte, end_of_write
//   res     | res_valid, res_ready, res_word   | destination, out_byte, last
//   cfg     | cfg_valid, cfg_ready (always 1)  | cfg_index, cfg_data
//
// an input word is taken only in the idle state; then each fixed result
// (echo, event, slave byte) goes out in turn, then any erase echo characters, or the
// stored bytes of a line commit and its closing newline
// the stored bytes of a line commit are read through the registered line store read port
// reset loads register defaults, clears the line length; only entries below it are read
// a stalled res side holds one word in the output register; the next input word is taken
// only after the last result of the current one has been loaded into that register
`default_nettype none

module tty_line_discipline
	import ttyld_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input words
	input  wire logic                 src_valid,
	output logic                      src_ready,
	input  wire in_word_t             src_word,
	// result words
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output out_word_t                 res_word,
	// register writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	cfg_t             cfg;
	plan_t            plan;
	ram_wr_t          dec_wr;
	ram_wr_t          ram_wr;
	logic [LEN_W-1:0] line_len;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]       rd_data;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	ttyld_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// decode against the current line length; only used in the accept cycle
	ttyld_decode u_decode (
		.word (src_word),
		.cfg  (cfg),
		.len  (line_len),
		.plan (plan),
		.wr   (dec_wr)
	);

	// a character lands in the store only when its word is accepted; reads happen
	// only while the sequencer is busy, so a write never meets a read of the same entry
	always_comb begin
		ram_wr    = dec_wr;
		ram_wr.en = dec_wr.en & src_valid & src_ready;
	end

	ttyld_line_ram u_line_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ttyld_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.plan      (plan),
		.len       (line_len),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

`default_nettype wire

/* src/ttyld_cfg.sv */
// configuration registers of the tty line discipline
// depends on ttyld_pkg
`default_nettype none

module ttyld_cfg
	import ttyld_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [7:0]           wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{map_cr: 1'b1, lmodes: 4'hF, crlf: 1'b1, intr: DEF_INTR,
				susp: DEF_SUSP, erase: DEF_ERASE, kill: DEF_KILL, eof: DEF_EOF};
		end else if (wr_en) begin
			case (wr_index)
				CFG_MAP_CR: cfg_q.map_cr <= wr_data[0];
				CFG_LMODES: cfg_q.lmodes <= wr_data[3:0];
				CFG_CRLF:   cfg_q.crlf   <= wr_data[0];
				CFG_INTR:   cfg_q.intr   <= (wr_data != 8'h00) ? wr_data : DEF_INTR;
				CFG_SUSP:   cfg_q.susp   <= (wr_data != 8'h00) ? wr_data : DEF_SUSP;
				CFG_ERASE:  cfg_q.erase  <= (wr_data != 8'h00) ? wr_data : DEF_ERASE;
				CFG_KILL:   cfg_q.kill   <= wr_data;
				CFG_EOF:    cfg_q.eof    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/ttyld_decode.sv */
// classifies one input word and plans its results and line edit
// depends on ttyld_pkg
`default_nettype none

module ttyld_decode
	import ttyld_pkg::*;
(
	input  wire in_word_t          word,
	input  wire cfg_t              cfg,
	input  wire logic [LEN_W-1:0]  len,
	output plan_t                  plan,
	output ram_wr_t                wr
);

	logic [7:0] c;
	logic       is_print;
	logic       echo;

	always_comb begin
		c        = (cfg.map_cr && word.data_byte == CH_CR) ? CH_NL : word.data_byte;
		is_print = (c == CH_TAB) || (c >= CH_SP && c < CH_DEL);
		echo     = cfg.lmodes[LM_ECHO];
		plan         = '0;
		plan.new_len = len;
		wr           = '{en: 1'b0, addr: len[ADDR_W-1:0], data: c};

		if (word.opcode) begin
			// slave side output processing
			if (cfg.crlf && word.data_byte == CH_NL) begin
				plan.head[0]  = '{dest: DEST_MASTER, val: CH_CR};
				plan.head[1]  = '{dest: DEST_MASTER, val: CH_NL};
				plan.head_cnt = HEAD_CNT_W'(2);
			end else begin
				plan.head[0]  = '{dest: DEST_MASTER, val: word.data_byte};
				plan.head_cnt = HEAD_CNT_W'(1);
			end
		end else if (cfg.lmodes[LM_SIG] && (c == cfg.intr || c == cfg.susp)) begin
			plan.head[0]  = '{dest: (c == cfg.intr) ? DEST_INTR : DEST_SUSP, val: 8'h00};
			plan.head[1]  = '{dest: DEST_MASTER, val: CH_CARET};
			plan.head[2]  = '{dest: DEST_MASTER, val: (c == cfg.intr) ? CH_UC_C : CH_UC_Z};
			plan.head[3]  = '{dest: DEST_MASTER, val: CH_NL};
			plan.head_cnt = echo ? HEAD_CNT_W'(4) : HEAD_CNT_W'(1);
			plan.new_len  = '0;
		end else if (cfg.lmodes[LM_CANON]) begin
			if (c == cfg.erase || c == CH_BS) begin
				if (len != '0) begin
					plan.new_len = len - LEN_W'(1);
					plan.rub_cnt = cfg.lmodes[LM_ECHOE] ? LEN_W'(1) : '0;
				end
			end else if (c == cfg.kill) begin
				plan.new_len = '0;
				plan.rub_cnt = cfg.lmodes[LM_ECHOE] ? len : '0;
			end else if (c == cfg.eof) begin
				if (len != '0) begin
					plan.flush_cnt = len;
					plan.new_len   = '0;
				end else begin
					plan.head[0]  = '{dest: DEST_EOF, val: 8'h00};
					plan.head_cnt = HEAD_CNT_W'(1);
				end
			end else if (c == CH_NL) begin
				if (echo && cfg.crlf) begin
					plan.head[0]  = '{dest: DEST_MASTER, val: CH_CR};
					plan.head[1]  = '{dest: DEST_MASTER, val: CH_NL};
					plan.head_cnt = HEAD_CNT_W'(2);
				end else if (echo) begin
					plan.head[0]  = '{dest: DEST_MASTER, val: CH_NL};
					plan.head_cnt = HEAD_CNT_W'(1);
				end
				plan.flush_cnt = len;
				plan.tail      = 1'b1;
				plan.new_len   = '0;
			end else if (is_print) begin
				// full line drops the character, echo still goes out
				if (len < LEN_W'(LINE_DEPTH)) begin
					wr.en        = 1'b1;
					plan.new_len = len + LEN_W'(1);
				end
				plan.head[0]  = '{dest: DEST_MASTER, val: c};
				plan.head_cnt = echo ? HEAD_CNT_W'(1) : '0;
			end
		end else begin
			plan.head[0]  = '{dest: DEST_SLAVE, val: c};
			plan.head[1]  = '{dest: DEST_MASTER, val: c};
			plan.head_cnt = echo ? HEAD_CNT_W'(2) : HEAD_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

/* src/ttyld_line_ram.sv */
// edit line store: one write port, one registered read port
// depends on ttyld_pkg
`default_nettype none

module ttyld_line_ram
	import ttyld_pkg::*;
(
	input  wire logic              clk,
	input  wire ram_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]             rd_data
);

	logic [7:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* src/ttyld_seq.sv */
// result sequencer: walks a plan, reads the line store, drives the output register
// depends on ttyld_pkg
`default_nettype none

module ttyld_seq
	import ttyld_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_ready,
	input  wire plan_t             plan,
	output logic [LEN_W-1:0]       len,
	output logic                   rd_en,
	output logic [ADDR_W-1:0]      rd_addr,
	input  wire logic [7:0]        rd_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output out_word_t              res_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_RUB,
		ST_FL_RD,
		ST_FL_WAIT,
		ST_TAIL
	} state_t;

	state_t                state_q;
	plan_t                 plan_q;
	logic [HEAD_CNT_W-1:0] head_idx_q;
	logic [LEN_W-1:0]      rub_q;
	logic [1:0]            phase_q;
	logic [LEN_W-1:0]      fl_idx_q;
	logic [LEN_W-1:0]      len_q;
	logic                  res_valid_q;
	out_word_t             res_q;

	logic                  load;
	logic                  emit;
	out_word_t             emit_word;
	logic                  head_done;
	logic                  head_more;
	logic                  fl_end;
	state_t                after_head;

	assign load      = !res_valid_q || res_ready;
	assign src_ready = (state_q == ST_IDLE);
	assign head_done = (head_idx_q == plan_q.head_cnt);
	assign head_more = (HEAD_CNT_W'(head_idx_q + 1'b1) != plan_q.head_cnt) ||
		(plan_q.rub_cnt != '0) || (plan_q.flush_cnt != '0) || plan_q.tail;
	assign fl_end    = (LEN_W'(fl_idx_q + 1'b1) == plan_q.flush_cnt);

	always_comb begin
		if (plan_q.rub_cnt != '0) begin
			after_head = ST_RUB;
		end else if (plan_q.flush_cnt != '0) begin
			after_head = ST_FL_RD;
		end else if (plan_q.tail) begin
			after_head = ST_TAIL;
		end else begin
			after_head = ST_IDLE;
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_word = '0;
		rd_en     = (state_q == ST_FL_RD);
		rd_addr   = fl_idx_q[ADDR_W-1:0];
		case (state_q)
			ST_HEAD: begin
				if (!head_done && load) begin
					emit      = 1'b1;
					emit_word = '{destination: plan_q.head[head_idx_q[HEAD_IDX_W-1:0]].dest,
						out_byte: plan_q.head[head_idx_q[HEAD_IDX_W-1:0]].val,
						last: !head_more};
				end
			end
			ST_RUB: begin
				if (load) begin
					// backspace, space, backspace per removed character
					emit      = 1'b1;
					emit_word = '{destination: DEST_MASTER,
						out_byte: (phase_q == 2'd1) ? CH_SP : CH_BS,
						last: (phase_q == 2'd2) && (rub_q == LEN_W'(1))};
				end
			end
			ST_FL_WAIT: begin
				if (load) begin
					emit      = 1'b1;
					emit_word = '{destination: DEST_SLAVE, out_byte: rd_data,
						last: fl_end && !plan_q.tail};
				end
			end
			ST_TAIL: begin
				if (load) begin
					emit      = 1'b1;
					emit_word = '{destination: DEST_SLAVE, out_byte: CH_NL, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plan_q      <= '0;
			head_idx_q  <= '0;
			rub_q       <= '0;
			phase_q     <= '0;
			fl_idx_q    <= '0;
			len_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
				res_q       <= emit_word;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						plan_q     <= plan;
						len_q      <= plan.new_len;
						head_idx_q <= '0;
						rub_q      <= plan.rub_cnt;
						phase_q    <= '0;
						fl_idx_q   <= '0;
						state_q    <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (head_done) begin
						state_q <= after_head;
					end else if (load) begin
						head_idx_q <= HEAD_CNT_W'(head_idx_q + 1'b1);
					end
				end
				ST_RUB: begin
					if (load) begin
						if (phase_q == 2'd2) begin
							phase_q <= '0;
							rub_q   <= rub_q - LEN_W'(1);
							if (rub_q == LEN_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				ST_FL_RD: begin
					state_q <= ST_FL_WAIT;
				end
				ST_FL_WAIT: begin
					if (load) begin
						fl_idx_q <= LEN_W'(fl_idx_q + 1'b1);
						if (!fl_end) begin
							state_q <= ST_FL_RD;
						end else if (plan_q.tail) begin
							state_q <= ST_TAIL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TAIL: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign len       = len_q;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

`default_nettype wire

/* src/ttyld_checker.sv */
// port-level checks on the result channel of the tty line discipline
// depends on ttyld_pkg and tty_line_discipline_assert.svh; bound to the top level
`default_nettype none

`include "tty_line_discipline_assert.svh"

module ttyld_checker
	import ttyld_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire out_word_t res_word
);

	// a stalled word stays put
	`TTYLD_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_word))

	// only the five destinations exist
	`TTYLD_ASSERT_IMP(a_dest_range, clk, arst_n, res_valid, res_word.destination <= DEST_EOF)

	// events carry no byte
	`TTYLD_ASSERT_IMP(a_event_zero, clk, arst_n, res_valid && res_word.destination >= DEST_INTR, res_word.out_byte == 8'h00)

	// end of file on an empty line is the only result of its word
	`TTYLD_ASSERT_IMP(a_eof_last, clk, arst_n, res_valid && res_word.destination == DEST_EOF, res_word.last)

endmodule

bind tty_line_discipline ttyld_checker u_ttyld_checker (.*);

`default_nettype wire

/* bench/tty_line_discipline_tb.sv */
// self-checking bench for tty_line_discipline: directed and random words, checked against a predictor
// depends on ttyld_pkg and the tty_line_discipline rtl
`default_nettype none

module tty_line_discipline_tb;
	import ttyld_pkg::*;

	localparam logic OP_MASTER = 1'b0;
	localparam logic OP_SLAVE  = 1'b1;

	// a kill with erase echo on a full line gives 48 results
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            src_valid = 1'b0;
	logic            src_ready;
	in_word_t        src_word = '0;
	logic            res_valid;
	logic            res_ready = 1'b0;
	out_word_t       res_word;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]      cfg_data = '0;

	// handshake flags sampled at the rising edge, used by the falling-edge drivers
	logic            src_fire = 1'b0;
	logic            cfg_fire = 1'b0;

	// idling knobs, changed only at rising edges
	int unsigned     src_idle_pct = 0;
	int unsigned     res_stall_pct = 0;
	bit              res_hold = 1'b0;

	int unsigned     cycle_cnt = 0;
	int unsigned     fail_cnt = 0;
	int unsigned     queued_cnt = 0;
	int unsigned     taken_cnt = 0;

	in_word_t        pending_words[$];
	out_word_t       tty_results_due[$];
	out_word_t       step_results[$];

	// predictor state: register copy and the edit line
	cfg_t            tty_cfg = '{map_cr: 1'b1, lmodes: 4'hF, crlf: 1'b1, intr: DEF_INTR,
		susp: DEF_SUSP, erase: DEF_ERASE, kill: DEF_KILL, eof: DEF_EOF};
	logic [7:0]      edit_line [LINE_DEPTH];
	int unsigned     line_fill = 0;

	tty_line_discipline DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void add_result(logic [2:0] dest, logic [7:0] val);
		out_word_t w;
		w.destination = dest;
		w.out_byte = val;
		w.last = 1'b0;
		step_results.push_back(w);
	endfunction

	// backspace, space, backspace per removed character
	function automatic void rubout_echo();
		if (tty_cfg.lmodes[LM_ECHOE]) begin
			add_result(DEST_MASTER, CH_BS);
			add_result(DEST_MASTER, CH_SP);
			add_result(DEST_MASTER, CH_BS);
		end
	endfunction

	function automatic void commit_line();
		for (int unsigned i = 0; i < line_fill; i++)
			add_result(DEST_SLAVE, edit_line[i]);
		line_fill = 0;
	endfunction

	// event first, then the caret echo; the edit line is thrown away
	function automatic void signal_event(logic [2:0] dest, logic [7:0] letter);
		add_result(dest, 8'h00);
		if (tty_cfg.lmodes[LM_ECHO]) begin
			add_result(DEST_MASTER, CH_CARET);
			add_result(DEST_MASTER, letter);
			add_result(DEST_MASTER, CH_NL);
		end
		line_fill = 0;
	endfunction

	function automatic void master_input(logic [7:0] raw);
		logic [7:0] c;
		logic       sig_on;
		logic       echo_on;
		c = raw;
		sig_on = tty_cfg.lmodes[LM_SIG];
		echo_on = tty_cfg.lmodes[LM_ECHO];
		if (tty_cfg.map_cr && c == CH_CR)
			c = CH_NL;
		// interrupt wins over suspend when both match
		if (sig_on && c == tty_cfg.intr) begin
			signal_event(DEST_INTR, CH_UC_C);
		end else if (sig_on && c == tty_cfg.susp) begin
			signal_event(DEST_SUSP, CH_UC_Z);
		end else if (!tty_cfg.lmodes[LM_CANON]) begin
			// raw mode: straight through, then echo
			add_result(DEST_SLAVE, c);
			if (echo_on)
				add_result(DEST_MASTER, c);
		end else if (c == tty_cfg.erase || c == CH_BS) begin
			if (line_fill > 0) begin
				line_fill--;
				rubout_echo();
			end
		end else if (c == tty_cfg.kill) begin
			while (line_fill > 0) begin
				line_fill--;
				rubout_echo();
			end
		end else if (c == tty_cfg.eof) begin
			// non-empty line goes out unechoed, empty line means end of file
			if (line_fill > 0)
				commit_line();
			else
				add_result(DEST_EOF, 8'h00);
		end else if (c == CH_NL) begin
			if (echo_on) begin
				if (tty_cfg.crlf)
					add_result(DEST_MASTER, CH_CR);
				add_result(DEST_MASTER, CH_NL);
			end
			commit_line();
			add_result(DEST_SLAVE, CH_NL);
		end else if (c == CH_TAB || (c >= CH_SP && c < CH_DEL)) begin
			// a full line drops the character but still echoes it
			if (line_fill < LINE_DEPTH) begin
				edit_line[line_fill] = c;
				line_fill++;
			end
			if (echo_on)
				add_result(DEST_MASTER, c);
		end
		// any other control byte in canonical mode is swallowed
	endfunction

	function automatic void predict_tty_results(in_word_t w);
		out_word_t r;
		step_results.delete();
		if (w.opcode == OP_SLAVE) begin
			if (tty_cfg.crlf && w.data_byte == CH_NL)
				add_result(DEST_MASTER, CH_CR);
			add_result(DEST_MASTER, w.data_byte);
		end else begin
			master_input(w.data_byte);
		end
		for (int i = 0; i < step_results.size(); i++) begin
			r = step_results[i];
			r.last = (i == step_results.size() - 1);
			tty_results_due.push_back(r);
		end
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		case (idx)
			CFG_MAP_CR: tty_cfg.map_cr = val[0];
			CFG_LMODES: tty_cfg.lmodes = val[3:0];
			CFG_CRLF:   tty_cfg.crlf = val[0];
			CFG_INTR:   tty_cfg.intr = (val != 8'h00) ? val : DEF_INTR;
			CFG_SUSP:   tty_cfg.susp = (val != 8'h00) ? val : DEF_SUSP;
			CFG_ERASE:  tty_cfg.erase = (val != 8'h00) ? val : DEF_ERASE;
			CFG_KILL:   tty_cfg.kill = val;
			CFG_EOF:    tty_cfg.eof = val;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (fail_cnt < 100)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
		fail_cnt++;
	endtask

	// ---------------------------------------------------------------- monitor

	// rising edge: check result words, track register writes and input words
	always @(posedge clk) begin : monitor
		out_word_t got;
		out_word_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			src_fire <= arst_n && src_valid && src_ready;
			cfg_fire <= arst_n && cfg_valid && cfg_ready;
			if (arst_n) begin
				if (res_valid && res_ready) begin
					got = res_word;
					if (tty_results_due.size() == 0) begin
						report_mismatch($sformatf("unexpected word dest %0d byte %h last %b",
							got.destination, got.out_byte, got.last));
					end else begin
						want = tty_results_due.pop_front();
						if (got.destination !== want.destination || got.out_byte !== want.out_byte
								|| got.last !== want.last)
							report_mismatch($sformatf(
								"got dest %0d byte %h last %b, want dest %0d byte %h last %b",
								got.destination, got.out_byte, got.last,
								want.destination, want.out_byte, want.last));
					end
				end
				if (cfg_valid && cfg_ready)
					apply_reg(cfg_index, cfg_data);
				if (src_valid && src_ready) begin
					taken_cnt++;
					predict_tty_results(src_word);
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// input words: next word once the current one is taken, with random gaps
	always @(negedge clk) begin
		if (!src_valid || src_fire) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				src_word <= pending_words.pop_front();
				src_valid <= 1'b1;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// result side: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		res_ready <= !res_hold && ($urandom_range(99) >= res_stall_pct);
	end

	// ---------------------------------------------------------------- stimulus

	function automatic void queue_word(logic op, logic [7:0] b);
		in_word_t w;
		w.opcode = op;
		w.data_byte = b;
		w.end_of_write = 1'($urandom_range(1));
		pending_words.push_back(w);
		queued_cnt++;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] b;
		if ($urandom_range(7) == 0)
			b = CH_TAB;
		else
			b = 8'($urandom_range(126, 32));
		return b;
	endfunction

	// mostly edited lines with a terminator, the rest stray bytes from either side
	function automatic void gen_traffic(int unsigned n_words);
		int unsigned made;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  b;
		made = 0;
		while (made < n_words) begin
			pick = (made == 0) ? 0 : $urandom_range(99);
			if (pick < 70) begin
				// a batch of 16 or more opens with a line of 16 to 21 words, at least a full line's worth
				len = ((made == 0 && n_words >= 16) || $urandom_range(3) == 0)
					? $urandom_range(21, 16) : $urandom_range(8);
				for (int unsigned k = 0; k < len; k++) begin
					if ($urandom_range(9) == 0)
						queue_word(OP_MASTER, $urandom_range(1) ? tty_cfg.erase : CH_BS);
					else
						queue_word(OP_MASTER, text_char());
				end
				case ($urandom_range(6))
					0: b = tty_cfg.kill;
					1: b = tty_cfg.eof;
					2: b = tty_cfg.intr;
					3: b = tty_cfg.susp;
					4: b = CH_CR;
					default: b = CH_NL;
				endcase
				queue_word(OP_MASTER, b);
				made += len + 1;
			end else if (pick < 85) begin
				b = ($urandom_range(3) == 0) ? CH_NL : 8'($urandom_range(255));
				queue_word(OP_SLAVE, b);
				made++;
			end else begin
				queue_word(OP_MASTER, 8'($urandom_range(255)));
				made++;
			end
		end
	endfunction

	// reset settings: every editing case at least once, then three slave words
	function automatic void directed_words();
		queue_word(OP_MASTER, 8'h61);
		queue_word(OP_MASTER, CH_TAB);
		queue_word(OP_MASTER, CH_BS);
		queue_word(OP_MASTER, CH_DEL);
		queue_word(OP_MASTER, CH_DEL);      // erase on empty line
		queue_word(OP_MASTER, 8'h01);       // stray control byte
		queue_word(OP_MASTER, DEF_EOF);     // end of file on empty line
		queue_word(OP_MASTER, CH_SP);
		queue_word(OP_MASTER, 8'h7E);
		queue_word(OP_MASTER, DEF_EOF);     // flushes the line
		queue_word(OP_MASTER, 8'h7A);
		queue_word(OP_MASTER, DEF_KILL);
		queue_word(OP_MASTER, 8'h6B);
		queue_word(OP_MASTER, CH_CR);       // mapped to newline
		queue_word(OP_MASTER, CH_NL);
		queue_word(OP_MASTER, DEF_INTR);
		queue_word(OP_MASTER, 8'h77);
		queue_word(OP_MASTER, DEF_SUSP);    // discards the pending line
		queue_word(OP_MASTER, 8'h80);
		queue_word(OP_MASTER, 8'hFF);
		queue_word(OP_SLAVE, CH_NL);
		queue_word(OP_SLAVE, 8'h00);
		queue_word(OP_SLAVE, 8'hFF);
	endfunction

	// called at a falling edge; valid stays up across back-to-back writes
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_fire);
	endtask

	task automatic load_settings(logic map_cr, logic [3:0] lmodes, logic crlf,
			logic [7:0] intr, logic [7:0] susp, logic [7:0] erase, logic [7:0] kill_c,
			logic [7:0] eof_c);
		write_reg(CFG_MAP_CR, {7'd0, map_cr});
		write_reg(CFG_LMODES, {4'd0, lmodes});
		write_reg(CFG_CRLF, {7'd0, crlf});
		write_reg(CFG_INTR, intr);
		write_reg(CFG_SUSP, susp);
		write_reg(CFG_ERASE, erase);
		write_reg(CFG_KILL, kill_c);
		write_reg(CFG_EOF, eof_c);
		cfg_valid <= 1'b0;
	endtask

	// all words taken, all results seen, then room for result-less words to finish
	task automatic wait_quiet();
		do @(negedge clk); while (taken_cnt != queued_cnt || tty_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n_words);
		@(posedge clk);
		src_idle_pct = idle;
		res_stall_pct = stall;
		gen_traffic(n_words);
		wait_quiet();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, no idling
		@(posedge clk);
		directed_words();
		wait_quiet();

		// all characters zero: defaults for interrupt, suspend, erase; nul kills
		load_settings(1'b0, 4'hF, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		run_phase(0, 0, 6);

		// raw mode with nothing on, all characters at the top
		load_settings(1'b1, 4'h0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_phase(74, 0, 6);

		// canonical, no signals, random control characters and a random erase byte
		load_settings(1'b1, 4'b0111, 1'b0, 8'($urandom_range(31)), 8'($urandom_range(31)),
			8'($urandom_range(255)), 8'($urandom_range(31)), 8'($urandom_range(31)));
		run_phase(0, 74, 6);

		// reset values written back; long receiver hold while words keep coming
		load_settings(1'b1, 4'hF, 1'b1, DEF_INTR, DEF_SUSP, DEF_ERASE, DEF_KILL, DEF_EOF);
		@(posedge clk);
		src_idle_pct = 0;
		res_stall_pct = 23;
		fork
			begin
				res_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_hold = 1'b0;
			end
		join_none
		gen_traffic(16);
		// wait until every word is taken and every result is out
		wait_quiet();
		run_phase(23, 23, 6);

		// raw mode with signals and echo
		load_settings(1'b0, 4'b1001, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		run_phase(23, 23, 6);

		// canonical with echo, no erase echo
		load_settings(1'b1, 4'b1101, 1'b1, DEF_INTR, DEF_SUSP, 8'h00, DEF_KILL, DEF_EOF);
		run_phase(23, 23, 6);

		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
